>>> src/rbsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, record types and arithmetic helpers of the ray/box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int CW = 32;               // coordinate width
   localparam int FB = 16;               // fraction bits
   localparam int DW = CW + 1 + FB;      // dividend and quotient width
   localparam int LANES = 6;
   localparam int AXES = 3;
   localparam int CSR_IDX_W = 2;
   localparam int THR_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_LOW  = 2'd0,
      CSR_BOX_HIGH = 2'd1,
      CSR_PAR_THR  = 2'd2
   } csr_index_type;

   localparam logic [CW-1:0] CODE_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] CODE_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [DW-1:0] LIM_POS  = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic [DW-1:0] LIM_NEG  = {{(DW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

   // One division in flight: partial remainder, and a word that shifts the
   // dividend out at the top while quotient bits enter at the bottom.
   typedef struct packed {
      logic [CW-1:0] rem;
      logic [DW-1:0] work;
      logic [CW-1:0] den;
      logic          neg;
   } lane_type;

   typedef struct packed {
      logic par;
      logic lo_pos;
      logic hi_neg;
   } axis_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      axis_type [AXES-1:0]  axis;
   } stage_type;

   // One restoring division step: one quotient bit.
   function automatic lane_type div_step(lane_type l);
      lane_type        o;
      logic [CW:0]     trial;
      logic [CW+1:0]   diff;
      logic            qbit;
      trial = {l.rem, l.work[DW-1]};
      diff  = {1'b0, trial} - {2'b00, l.den};
      qbit  = ~diff[CW+1];
      o     = l;
      o.rem = qbit ? diff[CW-1:0] : trial[CW-1:0];
      o.work = {l.work[DW-2:0], qbit};
      return o;
   endfunction

   // Saturate the quotient magnitude and apply the sign.
   function automatic logic [CW-1:0] sat_quot(logic [DW-1:0] q, logic neg);
      logic [CW-1:0] r;
      if (neg) begin
         r = (q > LIM_NEG) ? CODE_MIN : (~q[CW-1:0] + {{(CW-1){1'b0}}, 1'b1});
      end else begin
         r = (q > LIM_POS) ? CODE_MAX : q[CW-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/rbsi_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_prep
// Forms the slab numerators, direction magnitudes and parallel flags of an item.
// ----------------------------------------------------------------------------
module rbsi_prep
   import rbsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [CW-1:0]  origin [AXES],
   input  logic signed [CW-1:0]  dir [AXES],
   input  logic signed [CW-1:0]  box_low,
   input  logic signed [CW-1:0]  box_high,
   input  logic [THR_W-1:0]      par_thr,
   output logic                  out_valid,
   input  logic                  out_ready,
   output stage_type             out_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   always_comb begin
      logic [CW:0]   nlo;
      logic [CW:0]   nhi;
      logic [CW:0]   mlo;
      logic [CW:0]   mhi;
      logic [CW-1:0] md;
      data_in = '0;
      for (int a = 0; a < AXES; a++) begin
         nlo = {box_low[CW-1], box_low} - {origin[a][CW-1], origin[a]};
         nhi = {box_high[CW-1], box_high} - {origin[a][CW-1], origin[a]};
         mlo = nlo[CW] ? (~nlo + 1'b1) : nlo;
         mhi = nhi[CW] ? (~nhi + 1'b1) : nhi;
         md  = dir[a][CW-1] ? (~dir[a] + 1'b1) : dir[a];
         data_in.axis[a].par    = (md == '0) ||
                                  (md < {{(CW-THR_W){1'b0}}, par_thr});
         data_in.axis[a].lo_pos = ~nlo[CW] && (nlo != '0);
         data_in.axis[a].hi_neg = nhi[CW];
         data_in.lane[2*a].rem    = '0;
         data_in.lane[2*a].work   = {mlo, {FB{1'b0}}};
         data_in.lane[2*a].den    = md;
         data_in.lane[2*a].neg    = nlo[CW] ^ dir[a][CW-1];
         data_in.lane[2*a+1].rem  = '0;
         data_in.lane[2*a+1].work = {mhi, {FB{1'b0}}};
         data_in.lane[2*a+1].den  = md;
         data_in.lane[2*a+1].neg  = nhi[CW] ^ dir[a][CW-1];
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/rbsi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_cell
// One stage of the divider row: one quotient bit for all six divisions.
// ----------------------------------------------------------------------------
module rbsi_cell
   import rbsi_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < LANES; i++) begin
         data_in.lane[i] = div_step(in_data.lane[i]);
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/rbsi_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbsi_finish
// Saturates and orders the slab distances, then reduces them to the result.
// ----------------------------------------------------------------------------
module rbsi_finish
   import rbsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  stage_type            in_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic signed [CW-1:0] rsp_t_near,
   output logic signed [CW-1:0] rsp_t_far
);

   logic                 a_valid_ff;
   logic                 a_ready;
   logic signed [CW-1:0] enter_ff [AXES];
   logic signed [CW-1:0] leave_ff [AXES];
   logic signed [CW-1:0] enter_in [AXES];
   logic signed [CW-1:0] leave_in [AXES];

   logic                 b_valid_ff;
   logic                 hit_ff;
   logic signed [CW-1:0] near_ff;
   logic signed [CW-1:0] far_ff;
   logic signed [CW-1:0] near_in;
   logic signed [CW-1:0] far_in;

   always_comb begin
      logic signed [CW-1:0] lo;
      logic signed [CW-1:0] hi;
      for (int a = 0; a < AXES; a++) begin
         if (in_data.axis[a].par) begin
            // A parallel ray is inside the slab unless a plane lies strictly
            // on the wrong side of the origin.
            lo = in_data.axis[a].lo_pos ? CODE_MAX : CODE_MIN;
            hi = in_data.axis[a].hi_neg ? CODE_MIN : CODE_MAX;
         end else begin
            lo = sat_quot(in_data.lane[2*a].work, in_data.lane[2*a].neg);
            hi = sat_quot(in_data.lane[2*a+1].work, in_data.lane[2*a+1].neg);
         end
         enter_in[a] = (lo > hi) ? hi : lo;
         leave_in[a] = (lo > hi) ? lo : hi;
      end
   end

   assign in_ready = ~a_valid_ff | a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         enter_ff <= enter_in;
         leave_ff <= leave_in;
      end
   end

   always_comb begin
      near_in = enter_ff[0];
      far_in  = leave_ff[0];
      for (int a = 1; a < AXES; a++) begin
         if (enter_ff[a] > near_in) begin
            near_in = enter_ff[a];
         end
         if (leave_ff[a] < far_in) begin
            far_in = leave_ff[a];
         end
      end
   end

   assign a_ready = ~b_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && a_valid_ff) begin
         near_ff <= near_in;
         far_ff  <= far_in;
         hit_ff  <= (near_in <= far_in);
      end
   end

   assign rsp_valid  = b_valid_ff;
   assign rsp_hit    = hit_ff;
   assign rsp_t_near = near_ff;
   assign rsp_t_far  = far_ff;

`ifndef ASSERT_OFF
   a_hit_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_t_near <= rsp_t_far)))
      else $error("hit flag disagrees with the reported distances");
   a_near_is_max: assert property (@(posedge clock) disable iff (reset)
      (a_ready && a_valid_ff) |=> (near_ff >= $past(enter_ff[0])))
      else $error("entry distance below the first axis entry");
   a_far_is_min: assert property (@(posedge clock) disable iff (reset)
      (a_ready && a_valid_ff) |=> (far_ff <= $past(leave_ff[0])))
      else $error("exit distance above the first axis exit");
`endif

endmodule

>>> src/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box by the slab method, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// The block takes one ray per clock cycle while the result side does not stall,
// and returns one result per ray, in order. Each item passes a preparation
// register, a row of 49 divider cells (one quotient bit of all six slab
// divisions per cell) and two reduction registers, in that order. Each stage
// moves on whenever the stage after it is empty or moving, so a held result
// does not stop earlier stages filling.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
   import rbsi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [CW-1:0] req_origin_x,
   input  logic signed [CW-1:0] req_origin_y,
   input  logic signed [CW-1:0] req_origin_z,
   input  logic signed [CW-1:0] req_dir_x,
   input  logic signed [CW-1:0] req_dir_y,
   input  logic signed [CW-1:0] req_dir_z,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic signed [CW-1:0] rsp_t_near,
   output logic signed [CW-1:0] rsp_t_far,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CW-1:0]        csr_wdata
);

   logic signed [CW-1:0] box_low_ff;
   logic signed [CW-1:0] box_high_ff;
   logic [THR_W-1:0]     par_thr_ff;

   logic signed [CW-1:0] origin [AXES];
   logic signed [CW-1:0] dir [AXES];

   stage_type chain_data  [DW+1];
   logic      chain_valid [DW+1];
   logic      chain_ready [DW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         box_low_ff  <= -$signed(CW'(1) << FB);
         box_high_ff <= $signed(CW'(1) << FB);
         par_thr_ff  <= THR_W'(1);
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_BOX_LOW:  box_low_ff  <= csr_wdata;
            CSR_BOX_HIGH: box_high_ff <= csr_wdata;
            CSR_PAR_THR:  par_thr_ff  <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign origin[0] = req_origin_x;
   assign origin[1] = req_origin_y;
   assign origin[2] = req_origin_z;
   assign dir[0]    = req_dir_x;
   assign dir[1]    = req_dir_y;
   assign dir[2]    = req_dir_z;

   rbsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .origin    (origin),
      .dir       (dir),
      .box_low   (box_low_ff),
      .box_high  (box_high_ff),
      .par_thr   (par_thr_ff),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < DW; i++) begin : g_cell
      rbsi_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   rbsi_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[DW]),
      .in_ready   (chain_ready[DW]),
      .in_data    (chain_data[DW]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_hit    (rsp_hit),
      .rsp_t_near (rsp_t_near),
      .rsp_t_far  (rsp_t_far)
   );

`ifndef ASSERT_OFF
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("input not ready after reset");
   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline stalled while the result side is ready");
   a_thr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wen && csr_index == CSR_PAR_THR) |=> (par_thr_ff == $past(csr_wdata[THR_W-1:0])))
      else $error("threshold register missed a write");
`endif

endmodule
